FILE: rtl/pinhole_point_projection_core_macros.svh
// Assertion macros for the pinhole projection core.
`ifndef PINHOLE_POINT_PROJECTION_CORE_MACROS_SVH
`define PINHOLE_POINT_PROJECTION_CORE_MACROS_SVH

// same-cycle implication
`define PPP_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ppp assertion failed");

// next-cycle implication
`define PPP_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ppp assertion failed");

`endif

FILE: rtl/ppp_pkg.sv
// Types and constants shared by the pinhole projection core.
`default_nettype none

package ppp_pkg;

  localparam int unsigned COORD_W    = 32;
  localparam int unsigned DIVIDEND_W = 64;
  localparam int unsigned DEN_W      = 31;
  localparam int unsigned DIM_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic signed [COORD_W-1:0] NEAR_LIMIT = 32'sd65;

  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLS     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS     = 3'd5;

  typedef enum logic [1:0] {
    STATUS_INSIDE  = 2'd0,
    STATUS_NEAR    = 2'd1,
    STATUS_OUTSIDE = 2'd2
  } ppp_status_e;

  typedef struct packed {
    logic vld;
    logic near;
    logic neg_u;
    logic neg_v;
  } ppp_tag_t;

endpackage

`default_nettype wire

FILE: rtl/ppp_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, two lanes sharing a divisor.
`default_nettype none

module ppp_div_pipe (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  ppp_pkg::ppp_tag_t                  tag_i,
  input  logic [ppp_pkg::DIVIDEND_W-1:0]     num_u_i,
  input  logic [ppp_pkg::DIVIDEND_W-1:0]     num_v_i,
  input  logic [ppp_pkg::DEN_W-1:0]          den_i,
  output ppp_pkg::ppp_tag_t                  tag_o,
  output logic [ppp_pkg::DIVIDEND_W-1:0]     quo_u_o,
  output logic [ppp_pkg::DIVIDEND_W-1:0]     quo_v_o
);
  import ppp_pkg::*;

  localparam int unsigned NSTG = DIVIDEND_W;

  ppp_tag_t              tag_q   [1:NSTG];
  logic [DIVIDEND_W-1:0] dq_u_q  [1:NSTG];
  logic [DIVIDEND_W-1:0] dq_v_q  [1:NSTG];
  logic [DEN_W-1:0]      rem_u_q [1:NSTG-1];
  logic [DEN_W-1:0]      rem_v_q [1:NSTG-1];
  logic [DEN_W-1:0]      den_q   [1:NSTG-1];

  for (genvar k = 0; k < NSTG; k++) begin : g_stage
    ppp_tag_t              tag_s;
    logic [DIVIDEND_W-1:0] dq_u_s, dq_v_s;
    logic [DEN_W-1:0]      rem_u_s, rem_v_s, den_s;
    logic [DEN_W:0]        tr_u, tr_v;
    logic                  ge_u, ge_v;

    if (k == 0) begin : g_head
      assign tag_s   = tag_i;
      assign dq_u_s  = num_u_i;
      assign dq_v_s  = num_v_i;
      assign rem_u_s = '0;
      assign rem_v_s = '0;
      assign den_s   = den_i;
    end else begin : g_body
      assign tag_s   = tag_q[k];
      assign dq_u_s  = dq_u_q[k];
      assign dq_v_s  = dq_v_q[k];
      assign rem_u_s = rem_u_q[k];
      assign rem_v_s = rem_v_q[k];
      assign den_s   = den_q[k];
    end

    assign tr_u = {rem_u_s, dq_u_s[DIVIDEND_W-1]};
    assign tr_v = {rem_v_s, dq_v_s[DIVIDEND_W-1]};
    assign ge_u = (tr_u >= {1'b0, den_s});
    assign ge_v = (tr_v >= {1'b0, den_s});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[k+1] <= '0;
      end else if (en_i) begin
        tag_q[k+1] <= tag_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dq_u_q[k+1] <= {dq_u_s[DIVIDEND_W-2:0], ge_u};
        dq_v_q[k+1] <= {dq_v_s[DIVIDEND_W-2:0], ge_v};
      end
    end

    // remainder and divisor are not needed past the last stage
    if (k < NSTG - 1) begin : g_carry
      logic [DEN_W-1:0] df_u, df_v;

      assign df_u = tr_u[DEN_W-1:0] - den_s;
      assign df_v = tr_v[DEN_W-1:0] - den_s;

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_u_q[k+1] <= ge_u ? df_u : tr_u[DEN_W-1:0];
          rem_v_q[k+1] <= ge_v ? df_v : tr_v[DEN_W-1:0];
          den_q[k+1]   <= den_s;
        end
      end
    end
  end

  assign tag_o   = tag_q[NSTG];
  assign quo_u_o = dq_u_q[NSTG];
  assign quo_v_o = dq_v_q[NSTG];

endmodule

`default_nettype wire

FILE: rtl/pinhole_point_projection_core.sv
// Top level of the pinhole point projection core.
//
//   channel   dir   handshake              payload
//   s_*       in    s_tvalid_i/s_tready_o  s_tdata_i: point_x, point_y, point_z
//   m_*       out   m_tvalid_o/m_tready_i  m_tdata_o: pixel_u, pixel_v, status
//   cfg_*     in    cfg_we_i               cfg_index_i, cfg_wdata_i
//
// One point per cycle sustained while the output skid register is empty.
// 71 registers in line: six math stages, the 64-stage divider and the output register.
// Reset clears valid bits and loads the default intrinsics; no clearing pass.
// The pipeline freezes only while the output skid register is occupied.
`default_nettype none
`include "pinhole_point_projection_core_macros.svh"

module pinhole_point_projection_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid_i,
  output logic                           s_tready_o,
  input  logic [95:0]                    s_tdata_i,   // point_x, point_y, point_z
  output logic                           m_tvalid_o,
  input  logic                           m_tready_i,
  output logic [71:0]                    m_tdata_o,   // pixel_u, pixel_v, status, zero pad
  input  logic                           cfg_we_i,
  input  logic [ppp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [31:0]                    cfg_wdata_i
);
  import ppp_pkg::*;

  // config
  logic [31:0]       focal_x_q, focal_y_q;
  logic [31:0]       center_x_q, center_y_q;
  logic [DIM_W-1:0]  cols_q, rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q  <= 32'd33554432;
      focal_y_q  <= 32'd33554432;
      center_x_q <= 32'd20971520;
      center_y_q <= 32'd15728640;
      cols_q     <= 16'd640;
      rows_q     <= 16'd480;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FOCAL_X:  focal_x_q  <= cfg_wdata_i;
        REG_FOCAL_Y:  focal_y_q  <= cfg_wdata_i;
        REG_CENTER_X: center_x_q <= cfg_wdata_i;
        REG_CENTER_Y: center_y_q <= cfg_wdata_i;
        REG_COLS:     cols_q     <= cfg_wdata_i[DIM_W-1:0];
        REG_ROWS:     rows_q     <= cfg_wdata_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic skid_vld_q;
  assign en         = !skid_vld_q;
  assign s_tready_o = en;

  // S1: capture
  logic              s1_vld_q;
  logic [COORD_W-1:0] s1_x_q, s1_y_q, s1_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= s_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_x_q <= s_tdata_i[31:0];
      s1_y_q <= s_tdata_i[63:32];
      s1_z_q <= s_tdata_i[95:64];
    end
  end

  // S2: near test, magnitudes
  ppp_tag_t           s2_tag_q;
  logic [COORD_W-1:0] s2_mag_x_q, s2_mag_y_q;
  logic [DEN_W-1:0]   s2_den_q;
  ppp_tag_t           s2_tag_d;

  assign s2_tag_d.vld   = s1_vld_q;
  assign s2_tag_d.near  = ($signed(s1_z_q) <= NEAR_LIMIT);
  assign s2_tag_d.neg_u = s1_x_q[COORD_W-1];
  assign s2_tag_d.neg_v = s1_y_q[COORD_W-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_tag_q <= '0;
    end else if (en) begin
      s2_tag_q <= s2_tag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_mag_x_q <= s1_x_q[COORD_W-1] ? (~s1_x_q + 32'd1) : s1_x_q;
      s2_mag_y_q <= s1_y_q[COORD_W-1] ? (~s1_y_q + 32'd1) : s1_y_q;
      s2_den_q   <= s1_z_q[DEN_W-1:0];
    end
  end

  // S3: focal products
  ppp_tag_t              s3_tag_q;
  logic [DIVIDEND_W-1:0] s3_prod_u_q, s3_prod_v_q;
  logic [DEN_W-1:0]      s3_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_tag_q <= '0;
    end else if (en) begin
      s3_tag_q <= s2_tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_prod_u_q <= 64'(focal_x_q) * 64'(s2_mag_x_q);
      s3_prod_v_q <= 64'(focal_y_q) * 64'(s2_mag_y_q);
      s3_den_q    <= s2_den_q;
    end
  end

  // divide
  ppp_tag_t              dv_tag;
  logic [DIVIDEND_W-1:0] dv_quo_u, dv_quo_v;

  ppp_div_pipe u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .tag_i   (s3_tag_q),
    .num_u_i (s3_prod_u_q),
    .num_v_i (s3_prod_v_q),
    .den_i   (s3_den_q),
    .tag_o   (dv_tag),
    .quo_u_o (dv_quo_u),
    .quo_v_o (dv_quo_v)
  );

  // S4: restore sign
  ppp_tag_t                    s4_tag_q;
  logic signed [DIVIDEND_W:0]  s4_su_q, s4_sv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_tag_q <= '0;
    end else if (en) begin
      s4_tag_q <= dv_tag;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_su_q <= dv_tag.neg_u ? -$signed({1'b0, dv_quo_u}) : $signed({1'b0, dv_quo_u});
      s4_sv_q <= dv_tag.neg_v ? -$signed({1'b0, dv_quo_v}) : $signed({1'b0, dv_quo_v});
    end
  end

  // S5: add principal point, saturate
  ppp_tag_t            s5_tag_q;
  logic [COORD_W-1:0]  s5_u_q, s5_v_q;
  logic [DIVIDEND_W+1:0] sum_u, sum_v;
  logic                ovf_u, ovf_v;
  logic [COORD_W-1:0]  sat_u, sat_v;

  assign sum_u = {s4_su_q[DIVIDEND_W], s4_su_q}
               + {{(DIVIDEND_W+2-COORD_W){center_x_q[COORD_W-1]}}, center_x_q};
  assign sum_v = {s4_sv_q[DIVIDEND_W], s4_sv_q}
               + {{(DIVIDEND_W+2-COORD_W){center_y_q[COORD_W-1]}}, center_y_q};
  assign ovf_u = !((&sum_u[DIVIDEND_W+1:COORD_W-1]) || !(|sum_u[DIVIDEND_W+1:COORD_W-1]));
  assign ovf_v = !((&sum_v[DIVIDEND_W+1:COORD_W-1]) || !(|sum_v[DIVIDEND_W+1:COORD_W-1]));
  assign sat_u = !ovf_u ? sum_u[COORD_W-1:0]
               : (sum_u[DIVIDEND_W+1] ? 32'h8000_0000 : 32'h7FFF_FFFF);
  assign sat_v = !ovf_v ? sum_v[COORD_W-1:0]
               : (sum_v[DIVIDEND_W+1] ? 32'h8000_0000 : 32'h7FFF_FFFF);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_tag_q <= '0;
    end else if (en) begin
      s5_tag_q <= s4_tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_u_q <= sat_u;
      s5_v_q <= sat_v;
    end
  end

  // S6: bounds, status
  logic                s6_vld_q;
  logic [COORD_W-1:0]  s6_u_q, s6_v_q;
  ppp_status_e         s6_st_q;
  logic signed [17:0]  cols_m1, rows_m1;
  logic signed [33:0]  ulim, vlim;
  logic                outside;
  ppp_status_e         s6_st_d;

  assign cols_m1 = $signed({2'b00, cols_q}) - 18'sd1;
  assign rows_m1 = $signed({2'b00, rows_q}) - 18'sd1;
  assign ulim    = {cols_m1, 16'h0000};
  assign vlim    = {rows_m1, 16'h0000};
  assign outside = s5_u_q[COORD_W-1] || s5_v_q[COORD_W-1]
                || ($signed({{2{s5_u_q[COORD_W-1]}}, s5_u_q}) > ulim)
                || ($signed({{2{s5_v_q[COORD_W-1]}}, s5_v_q}) > vlim);

  always_comb begin
    priority if (s5_tag_q.near) begin
      s6_st_d = STATUS_NEAR;
    end else if (outside) begin
      s6_st_d = STATUS_OUTSIDE;
    end else begin
      s6_st_d = STATUS_INSIDE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_vld_q <= 1'b0;
    end else if (en) begin
      s6_vld_q <= s5_tag_q.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_u_q  <= s5_tag_q.near ? '0 : s5_u_q;
      s6_v_q  <= s5_tag_q.near ? '0 : s5_v_q;
      s6_st_q <= s6_st_d;
    end
  end

  // output register and skid
  logic               out_vld_q, out_vld_d, skid_vld_d;
  logic [COORD_W-1:0] out_pu_q, out_pv_q, skid_pu_q, skid_pv_q;
  ppp_status_e        out_st_q, skid_st_q;
  logic               ld_out_new, ld_out_skid, ld_skid;

  always_comb begin
    out_vld_d   = out_vld_q;
    skid_vld_d  = skid_vld_q;
    ld_out_new  = 1'b0;
    ld_out_skid = 1'b0;
    ld_skid     = 1'b0;
    if (skid_vld_q) begin
      if (m_tready_i) begin
        ld_out_skid = 1'b1;
        skid_vld_d  = 1'b0;
      end
    end else if (s6_vld_q) begin
      if (!out_vld_q || m_tready_i) begin
        ld_out_new = 1'b1;
        out_vld_d  = 1'b1;
      end else begin
        ld_skid    = 1'b1;
        skid_vld_d = 1'b1;
      end
    end else if (m_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_out_new) begin
      out_pu_q <= s6_u_q;
      out_pv_q <= s6_v_q;
      out_st_q <= s6_st_q;
    end else if (ld_out_skid) begin
      out_pu_q <= skid_pu_q;
      out_pv_q <= skid_pv_q;
      out_st_q <= skid_st_q;
    end
    if (ld_skid) begin
      skid_pu_q <= s6_u_q;
      skid_pv_q <= s6_v_q;
      skid_st_q <= s6_st_q;
    end
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = {6'b000000, out_st_q, out_pv_q, out_pu_q};

  `PPP_ASSERT_IMPL(a_skid_needs_out, skid_vld_q, out_vld_q)
  `PPP_ASSERT_NEXT(a_skid_drains, skid_vld_q && m_tready_i, !skid_vld_q && out_vld_q)
  `PPP_ASSERT_IMPL(a_near_zero, out_vld_q && out_st_q == STATUS_NEAR, ~|{out_pu_q, out_pv_q})
  `PPP_ASSERT_IMPL(a_inside_pos, out_vld_q && out_st_q == STATUS_INSIDE, ~out_pu_q[31] & ~out_pv_q[31])

endmodule

`default_nettype wire
